// ===== design/assert_macros.svh =====
// Assertion macros shared by the drawing engine RTL.
// Both macros expect a clock named clk in scope; MFDE_ASSERT also expects an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define MFDE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MFDE_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/mfde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mfde_pkg;

	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;

	// Signed working width of a screen coordinate: centre plus or minus radius.
	localparam int COORD_W = 13;
	// Signed width of the midpoint circle decision variable.
	localparam int DEC_W   = 16;

	localparam int ROWS_PER_PAGE = 8;
	localparam logic [7:0] BYTE_CLEAR = 8'h00;
	localparam logic [7:0] BYTE_SET   = 8'hFF;

	typedef enum logic [2:0] {
		OP_PIXEL   = 3'd0,
		OP_LINE    = 3'd1,
		OP_CIRCLE  = 3'd2,
		OP_FCIRCLE = 3'd3,
		OP_FILL    = 3'd4,
		OP_INVERT  = 3'd5,
		OP_READ    = 3'd6
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_LINE_SETUP,
		ST_LINE_INIT,
		ST_LINE,
		ST_CIRC_PT,
		ST_CIRC_NEXT,
		ST_CIRC_STEP,
		ST_SPAN,
		ST_PLOT_RD,
		ST_PLOT_WR,
		ST_READ,
		ST_READ_WAIT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== design/mfde_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mfde_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         op;
	logic signed [10:0] ax;
	logic signed [10:0] ay;
	logic [9:0]         bx;
	logic [9:0]         by;
	logic [9:0]         radius;
	logic               colour;
	logic [9:0]         byte_index;

	modport source (output valid, op, ax, ay, bx, by, radius, colour, byte_index,
		input ready);
	modport sink (input valid, op, ax, ay, bx, by, radius, colour, byte_index,
		output ready);
endinterface

interface mfde_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [2:0] op_done;

	modport source (output valid, read_data, op_done, input ready);
	modport sink (input valid, read_data, op_done, output ready);
endinterface

`default_nettype wire

// ===== design/mfde_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (en) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/mono_framebuffer_draw_engine.sv =====
// One command at a time: a command beat is taken only in the idle state, and the block
// goes back to idle only once the result beat of that command is registered, so a new
// command is never taken before the last one is through. Each plotted pixel is a read
// then a write of the single store port; an off-screen pixel skips the write. Reset is
// asynchronous and active low; afterwards a clearing pass writes zero to every store byte
// (1024 by default) before the first command beat.
`timescale 1ns / 1ps
`default_nettype none

module mono_framebuffer_draw_engine #(
	parameter int SCREEN_WIDTH  = mfde_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = mfde_pkg::SCREEN_HEIGHT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	mfde_cmd_if.sink   cmd,
	mfde_rsp_if.source rsp
);

	localparam int CW          = mfde_pkg::COORD_W;
	localparam int FW          = mfde_pkg::DEC_W;
	localparam int PAGE_COUNT  = (SCREEN_HEIGHT + mfde_pkg::ROWS_PER_PAGE - 1)
		/ mfde_pkg::ROWS_PER_PAGE;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
	localparam int AW          = $clog2(STORE_BYTES);

	localparam logic signed [CW-1:0] WS  = CW'(SCREEN_WIDTH);
	localparam logic signed [CW-1:0] HS  = CW'(SCREEN_HEIGHT);
	localparam logic signed [CW-1:0] WM1 = CW'(SCREEN_WIDTH - 1);
	localparam logic signed [CW-1:0] HM1 = CW'(SCREEN_HEIGHT - 1);

	// The store holds every byte complemented while the invert flag is set. A toggle
	// then costs nothing, a plotted pixel writes its colour bit straight in, and reads
	// undo the complement on the way out.

	mfde_pkg::state_t state_q, state_d, ret_q;
	mfde_pkg::op_t    op_q;

	logic               clr_q, inv_q;
	logic [AW-1:0]      sw_q;
	logic               col_q;
	logic signed [10:0] ax_q, ay_q;
	logic [9:0]         bx_q, by_q, bidx_q;
	logic [7:0]         rd_q;

	logic signed [CW-1:0] px_q, py_q;
	logic signed [CW-1:0] lx_q, ly_q, lx1_q, ly1_q, ldx_q, ldy_q, err_q;
	logic                 lsxn_q, lsyn_q;
	logic signed [CW-1:0] x_q, y_q, sx_q, shi_q, srow_q;
	logic signed [FW-1:0] f_q;
	logic [2:0]           k_q;

	logic       out_v_q;
	logic [7:0] out_data_q;
	logic [2:0] out_op_q;

	logic cmd_fire, out_free, sw_last, on_scr, read_ok;

	logic          mem_en, mem_we;
	logic [AW-1:0] mem_addr, pix_addr;
	logic [7:0]    mem_wdata, mem_rdata, bit_mask;

	assign cmd_fire = cmd.valid && cmd.ready;
	assign out_free = !out_v_q || rsp.ready;
	assign sw_last  = (sw_q == AW'(STORE_BYTES - 1));
	assign read_ok  = (32'(cmd.byte_index) < 32'(STORE_BYTES));
	assign on_scr   = (px_q >= 0) && (px_q < WS) && (py_q >= 0) && (py_q < HS);

	// Byte address: column plus page times the screen width.
	assign pix_addr = AW'(px_q) + AW'(AW'(py_q >>> 3) * AW'(SCREEN_WIDTH));
	assign bit_mask = 8'd1 << py_q[2:0];

	// Line endpoint clamping.
	logic signed [CW-1:0] axs, ays, bxs, bys, lx_c, ly_c, lx1_c, ly1_c;
	assign axs   = CW'(ax_q);
	assign ays   = CW'(ay_q);
	assign bxs   = CW'(bx_q);
	assign bys   = CW'(by_q);
	assign lx_c  = (axs < 0) ? '0 : ((axs > WM1) ? WM1 : axs);
	assign ly_c  = (ays < 0) ? '0 : ((ays > HM1) ? HM1 : ays);
	assign lx1_c = (bxs > WM1) ? WM1 : bxs;
	assign ly1_c = (bys > HM1) ? HM1 : bys;

	// Line setup: deltas, step directions and the starting error term.
	logic signed [CW-1:0] dx_c, dy_c, err0_c;
	assign dx_c   = (lx_q < lx1_q) ? (lx1_q - lx_q) : (lx_q - lx1_q);
	assign dy_c   = (ly_q < ly1_q) ? (ly1_q - ly_q) : (ly_q - ly1_q);
	assign err0_c = (dx_c > dy_c) ? (dx_c >>> 1) : -(dy_c >>> 1);

	// One Bresenham step.
	logic                 st_x, st_y, line_end;
	logic signed [CW-1:0] err_n, lx_n, ly_n;
	assign st_x     = (err_q > -ldx_q);
	assign st_y     = (err_q < ldy_q);
	assign err_n    = err_q - (st_x ? ldy_q : '0) + (st_y ? ldx_q : '0);
	assign lx_n     = st_x ? (lsxn_q ? lx_q - CW'(1) : lx_q + CW'(1)) : lx_q;
	assign ly_n     = st_y ? (lsyn_q ? ly_q - CW'(1) : ly_q + CW'(1)) : ly_q;
	assign line_end = (lx_q == lx1_q) && (ly_q == ly1_q);

	// Circle octant points (outline) and spans (filled), picked by k_q.
	logic                 filled, k_last, span_skip;
	logic signed [CW-1:0] ca, cb, cpx, cpy, fa, fb, frow, flo, fhi;
	assign filled    = (op_q == mfde_pkg::OP_FCIRCLE);
	assign k_last    = filled ? (k_q == 3'd3) : (k_q == 3'd7);
	assign ca        = k_q[2] ? y_q : x_q;
	assign cb        = k_q[2] ? x_q : y_q;
	assign cpx       = k_q[0] ? axs - ca : axs + ca;
	assign cpy       = k_q[1] ? ays - cb : ays + cb;
	assign fa        = k_q[1] ? y_q : x_q;
	assign fb        = k_q[1] ? x_q : y_q;
	assign frow      = k_q[0] ? ays - fb : ays + fb;
	assign flo       = axs - fa;
	assign fhi       = axs + fa;
	assign span_skip = (frow < 0) || (frow >= HS) || (flo > WM1) || (fhi < 0);

	// Midpoint circle update.
	logic                 f_pos;
	logic signed [CW-1:0] y_n, x_n;
	logic signed [FW-1:0] f_n;
	assign f_pos = (f_q >= 0);
	assign y_n   = f_pos ? y_q - CW'(1) : y_q;
	assign x_n   = x_q + CW'(1);
	assign f_n   = f_q - (f_pos ? FW'(y_n) <<< 1 : '0) + (FW'(x_n) <<< 1) + FW'(1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mfde_pkg::ST_IDLE: begin
				if (clr_q) begin
					state_d = mfde_pkg::ST_SWEEP;
				end else if (cmd_fire) begin
					case (mfde_pkg::op_t'(cmd.op))
						mfde_pkg::OP_PIXEL:   state_d = mfde_pkg::ST_PLOT_RD;
						mfde_pkg::OP_LINE:    state_d = mfde_pkg::ST_LINE_SETUP;
						mfde_pkg::OP_CIRCLE:  state_d = mfde_pkg::ST_CIRC_PT;
						mfde_pkg::OP_FCIRCLE: state_d = mfde_pkg::ST_CIRC_PT;
						mfde_pkg::OP_FILL:    state_d = mfde_pkg::ST_SWEEP;
						mfde_pkg::OP_READ:
							state_d = read_ok ? mfde_pkg::ST_READ : mfde_pkg::ST_DONE;
						default:              state_d = mfde_pkg::ST_DONE;
					endcase
				end
			end
			mfde_pkg::ST_SWEEP: begin
				if (sw_last) begin
					state_d = clr_q ? mfde_pkg::ST_IDLE : mfde_pkg::ST_DONE;
				end
			end
			mfde_pkg::ST_LINE_SETUP: state_d = mfde_pkg::ST_LINE_INIT;
			mfde_pkg::ST_LINE_INIT:  state_d = mfde_pkg::ST_LINE;
			mfde_pkg::ST_LINE:       state_d = mfde_pkg::ST_PLOT_RD;
			mfde_pkg::ST_CIRC_PT: begin
				if (!filled) begin
					state_d = mfde_pkg::ST_PLOT_RD;
				end else begin
					state_d = span_skip ? mfde_pkg::ST_CIRC_NEXT : mfde_pkg::ST_SPAN;
				end
			end
			mfde_pkg::ST_CIRC_NEXT: begin
				if (!k_last) begin
					state_d = mfde_pkg::ST_CIRC_PT;
				end else begin
					state_d = (x_q < y_q) ? mfde_pkg::ST_CIRC_STEP : mfde_pkg::ST_DONE;
				end
			end
			mfde_pkg::ST_CIRC_STEP: state_d = mfde_pkg::ST_CIRC_PT;
			mfde_pkg::ST_SPAN:      state_d = mfde_pkg::ST_PLOT_RD;
			mfde_pkg::ST_PLOT_RD:   state_d = on_scr ? mfde_pkg::ST_PLOT_WR : ret_q;
			mfde_pkg::ST_PLOT_WR:   state_d = ret_q;
			mfde_pkg::ST_READ:      state_d = mfde_pkg::ST_READ_WAIT;
			mfde_pkg::ST_READ_WAIT: state_d = mfde_pkg::ST_DONE;
			mfde_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = mfde_pkg::ST_IDLE;
				end
			end
			default: state_d = mfde_pkg::ST_IDLE;
		endcase
	end

	// Store port and handshake outputs.
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = pix_addr;
		mem_wdata = col_q ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
		case (state_q)
			mfde_pkg::ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_addr  = sw_q;
				if (clr_q) begin
					mem_wdata = mfde_pkg::BYTE_CLEAR;
				end else begin
					mem_wdata = (col_q ^ inv_q) ? mfde_pkg::BYTE_SET : mfde_pkg::BYTE_CLEAR;
				end
			end
			mfde_pkg::ST_PLOT_RD: mem_en = on_scr;
			mfde_pkg::ST_PLOT_WR: mem_we = 1'b1;
			mfde_pkg::ST_READ: begin
				mem_en   = 1'b1;
				mem_addr = AW'(bidx_q);
			end
			default: ;
		endcase
	end

	assign cmd.ready     = (state_q == mfde_pkg::ST_IDLE) && !clr_q;
	assign rsp.valid     = out_v_q;
	assign rsp.read_data = out_data_q;
	assign rsp.op_done   = out_op_q;

	mfde_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfde_pkg::ST_IDLE;
			clr_q   <= 1'b1;
			inv_q   <= 1'b0;
			sw_q    <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_fire && (mfde_pkg::op_t'(cmd.op) == mfde_pkg::OP_INVERT)) begin
				inv_q <= ~inv_q;
			end
			if (state_q == mfde_pkg::ST_SWEEP) begin
				sw_q <= sw_last ? '0 : sw_q + 1'b1;
				if (sw_last) begin
					clr_q <= 1'b0;
				end
			end
			if ((state_q == mfde_pkg::ST_DONE) && out_free) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			mfde_pkg::ST_IDLE: begin
				if (cmd_fire) begin
					op_q   <= mfde_pkg::op_t'(cmd.op);
					ax_q   <= cmd.ax;
					ay_q   <= cmd.ay;
					bx_q   <= cmd.bx;
					by_q   <= cmd.by;
					bidx_q <= cmd.byte_index;
					col_q  <= cmd.colour;
					rd_q   <= '0;
					px_q   <= CW'(cmd.ax);
					py_q   <= CW'(cmd.ay);
					ret_q  <= mfde_pkg::ST_DONE;
					x_q    <= '0;
					y_q    <= CW'(cmd.radius);
					f_q    <= FW'(1) - FW'(cmd.radius);
					k_q    <= '0;
				end
			end
			mfde_pkg::ST_LINE_SETUP: begin
				lx_q  <= lx_c;
				ly_q  <= ly_c;
				lx1_q <= lx1_c;
				ly1_q <= ly1_c;
			end
			mfde_pkg::ST_LINE_INIT: begin
				ldx_q  <= dx_c;
				ldy_q  <= dy_c;
				err_q  <= err0_c;
				lsxn_q <= !(lx_q < lx1_q);
				lsyn_q <= !(ly_q < ly1_q);
			end
			mfde_pkg::ST_LINE: begin
				px_q <= lx_q;
				py_q <= ly_q;
				if (line_end) begin
					ret_q <= mfde_pkg::ST_DONE;
				end else begin
					ret_q <= mfde_pkg::ST_LINE;
					err_q <= err_n;
					lx_q  <= lx_n;
					ly_q  <= ly_n;
				end
			end
			mfde_pkg::ST_CIRC_PT: begin
				px_q   <= cpx;
				py_q   <= cpy;
				ret_q  <= mfde_pkg::ST_CIRC_NEXT;
				sx_q   <= (flo < 0) ? '0 : flo;
				shi_q  <= (fhi > WM1) ? WM1 : fhi;
				srow_q <= frow;
			end
			mfde_pkg::ST_CIRC_NEXT: k_q <= k_q + 3'd1;
			mfde_pkg::ST_CIRC_STEP: begin
				x_q <= x_n;
				y_q <= y_n;
				f_q <= f_n;
				k_q <= '0;
			end
			mfde_pkg::ST_SPAN: begin
				px_q <= sx_q;
				py_q <= srow_q;
				if (sx_q == shi_q) begin
					ret_q <= mfde_pkg::ST_CIRC_NEXT;
				end else begin
					ret_q <= mfde_pkg::ST_SPAN;
					sx_q  <= sx_q + CW'(1);
				end
			end
			mfde_pkg::ST_READ_WAIT: rd_q <= mem_rdata ^ {8{inv_q}};
			mfde_pkg::ST_DONE: begin
				if (out_free) begin
					out_data_q <= rd_q;
					out_op_q   <= op_q;
				end
			end
			default: ;
		endcase
	end

	logic in_plot_wr, in_sweep;
	assign in_plot_wr = (state_q == mfde_pkg::ST_PLOT_WR);
	assign in_sweep   = (state_q == mfde_pkg::ST_SWEEP);

	`include "assert_macros.svh"

	`MFDE_ASSERT(a_write_state, mem_we |-> (in_plot_wr || in_sweep), "stray store write")
	`MFDE_ASSERT(a_rmw_addr, in_plot_wr |-> (mem_addr == $past(mem_addr)), "pixel address moved")
	`MFDE_ASSERT(a_busy_after_accept, cmd_fire |=> !cmd.ready, "command taken while busy")
	`MFDE_ASSERT_NR(a_no_accept_in_clear, !(clr_q && cmd.ready), "ready during clearing pass")

endmodule

`default_nettype wire

// ===== dv/mono_framebuffer_draw_engine_chk.sv =====
`timescale 1ns / 1ps

module mono_framebuffer_draw_engine_chk #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_ready,
	input  logic [2:0] cmd_op,
	input  logic signed [10:0] cmd_ax,
	input  logic signed [10:0] cmd_ay,
	input  logic [9:0] cmd_bx,
	input  logic [9:0] cmd_by,
	input  logic [9:0] cmd_radius,
	input  logic cmd_colour,
	input  logic [9:0] cmd_byte_index,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  logic [7:0] rsp_read_data,
	input  logic [2:0] rsp_op_done,
	output int   errors,
	output int   pending,
	output int   reads_seen
);

	localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE = SCREEN_WIDTH * PAGES;

	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] op_done;
	} done_t;

	logic [7:0] shadow_store [STORE];
	logic       shadow_invert;
	done_t      done_q[$];

	function automatic void put_pixel(int x, int y, logic c);
		int idx;
		if (x < 0 || y < 0 || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT)
			return;
		idx = x + (y / 8) * SCREEN_WIDTH;
		if (c ^ shadow_invert)
			shadow_store[idx][y % 8] = 1'b1;
		else
			shadow_store[idx][y % 8] = 1'b0;
	endfunction

	function automatic void put_span(int xa, int xb, int y, logic c);
		int lo, hi;
		lo = xa < xb ? xa : xb;
		hi = xa < xb ? xb : xa;
		if (y < 0 || y >= SCREEN_HEIGHT)
			return;
		if (lo < 0)
			lo = 0;
		if (hi > SCREEN_WIDTH - 1)
			hi = SCREEN_WIDTH - 1;
		for (int x = lo; x <= hi; x++)
			put_pixel(x, y, c);
	endfunction

	function automatic int clampc(int v, int hi);
		return v < 0 ? 0 : (v > hi ? hi : v);
	endfunction

	function automatic void walk_line(int x0, int y0, int x1, int y1, logic c);
		int dx, dy, sx, sy, err, e2;
		x0 = clampc(x0, SCREEN_WIDTH - 1);
		x1 = clampc(x1, SCREEN_WIDTH - 1);
		y0 = clampc(y0, SCREEN_HEIGHT - 1);
		y1 = clampc(y1, SCREEN_HEIGHT - 1);
		dx = x0 < x1 ? x1 - x0 : x0 - x1;
		dy = y0 < y1 ? y1 - y0 : y0 - y1;
		sx = x0 < x1 ? 1 : -1;
		sy = y0 < y1 ? 1 : -1;
		err = dx > dy ? dx / 2 : -(dy / 2);
		if (dx == 0) begin
			for (int i = (y0 < y1 ? y0 : y1); i <= (y0 < y1 ? y1 : y0); i++)
				put_pixel(x0, i, c);
			return;
		end
		if (dy == 0) begin
			for (int i = (x0 < x1 ? x0 : x1); i <= (x0 < x1 ? x1 : x0); i++)
				put_pixel(i, y0, c);
			return;
		end
		forever begin
			put_pixel(x0, y0, c);
			if (x0 == x1 && y0 == y1)
				break;
			e2 = err;
			if (e2 > -dx) begin
				err -= dy;
				x0 += sx;
			end
			if (e2 < dy) begin
				err += dx;
				y0 += sy;
			end
		end
	endfunction

	function automatic void trace_circle(int cx, int cy, int r, logic c, bit filled);
		int f, ddx, ddy, x, y;
		f = 1 - r;
		ddx = 1;
		ddy = -2 * r;
		x = 0;
		y = r;
		put_pixel(cx, cy + r, c);
		put_pixel(cx, cy - r, c);
		put_pixel(cx + r, cy, c);
		put_pixel(cx - r, cy, c);
		if (filled)
			put_span(cx - r, cx + r, cy, c);
		while (x < y) begin
			if (f >= 0) begin
				y--;
				ddy += 2;
				f += ddy;
			end
			x++;
			ddx += 2;
			f += ddx;
			if (filled) begin
				put_span(cx - x, cx + x, cy + y, c);
				put_span(cx - x, cx + x, cy - y, c);
				put_span(cx - y, cx + y, cy + x, c);
				put_span(cx - y, cx + y, cy - x, c);
			end else begin
				put_pixel(cx + x, cy + y, c);
				put_pixel(cx - x, cy + y, c);
				put_pixel(cx + x, cy - y, c);
				put_pixel(cx - x, cy - y, c);
				put_pixel(cx + y, cy + x, c);
				put_pixel(cx - y, cy + x, c);
				put_pixel(cx + y, cy - x, c);
				put_pixel(cx - y, cy - x, c);
			end
		end
	endfunction

	function automatic done_t run_command();
		done_t d;
		d.read_data = 8'h00;
		d.op_done = cmd_op;
		case (cmd_op)
			mfde_pkg::OP_PIXEL: put_pixel(cmd_ax, cmd_ay, cmd_colour);
			mfde_pkg::OP_LINE: walk_line(cmd_ax, cmd_ay, cmd_bx, cmd_by, cmd_colour);
			mfde_pkg::OP_CIRCLE:
				trace_circle(cmd_ax, cmd_ay, cmd_radius, cmd_colour, 1'b0);
			mfde_pkg::OP_FCIRCLE:
				trace_circle(cmd_ax, cmd_ay, cmd_radius, cmd_colour, 1'b1);
			mfde_pkg::OP_FILL: begin
				for (int i = 0; i < STORE; i++)
					shadow_store[i] = cmd_colour ? mfde_pkg::BYTE_SET : mfde_pkg::BYTE_CLEAR;
			end
			mfde_pkg::OP_INVERT: begin
				shadow_invert = ~shadow_invert;
				for (int i = 0; i < STORE; i++)
					shadow_store[i] = ~shadow_store[i];
			end
			mfde_pkg::OP_READ: begin
				if (cmd_byte_index < STORE)
					d.read_data = shadow_store[cmd_byte_index];
			end
			default: ;
		endcase
		return d;
	endfunction

	initial begin
		errors = 0;
		reads_seen = 0;
		shadow_invert = 1'b0;
		for (int i = 0; i < STORE; i++)
			shadow_store[i] = 8'h00;
	end

	assign pending = done_q.size();

	always @(posedge clk) begin
		done_t got, want;
		if (arst_n) begin
			if (cmd_valid && cmd_ready)
				done_q.push_back(run_command());
			if (rsp_valid && rsp_ready) begin
				got.read_data = rsp_read_data;
				got.op_done = rsp_op_done;
				if (got.op_done == mfde_pkg::OP_READ)
					reads_seen++;
				if (done_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat op=%0d data=%h",
						$time, got.op_done, got.read_data);
				end else begin
					want = done_q.pop_front();
					if (got.op_done !== want.op_done) begin
						errors++;
						$display("%0t: op_done expected %0d actual %0d",
							$time, want.op_done, got.op_done);
					end
					if (got.read_data !== want.read_data) begin
						errors++;
						$display("%0t: read_data expected %h actual %h",
							$time, want.read_data, got.read_data);
					end
				end
			end
		end
	end
endmodule

// ===== dv/mono_framebuffer_draw_engine_tb.sv =====
`timescale 1ns / 1ps

module mono_framebuffer_draw_engine_tb;

	localparam int LIMIT_CYCLES = 10_000_000;
	// The one op code that the block leaves unused.
	localparam logic [2:0] OP_UNUSED = 3'd7;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   reads_seen;
	int   cycle_count;
	int   beats_sent;
	// While set, the result side holds ready low for a long stretch.
	logic hold_results;

	mfde_cmd_if cmd ();
	mfde_rsp_if rsp ();

	mono_framebuffer_draw_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.rsp(rsp.source)
	);

	mono_framebuffer_draw_engine_chk chk (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd.valid),
		.cmd_ready(cmd.ready),
		.cmd_op(cmd.op),
		.cmd_ax(cmd.ax),
		.cmd_ay(cmd.ay),
		.cmd_bx(cmd.bx),
		.cmd_by(cmd.by),
		.cmd_radius(cmd.radius),
		.cmd_colour(cmd.colour),
		.cmd_byte_index(cmd.byte_index),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.rsp_read_data(rsp.read_data),
		.rsp_op_done(rsp.op_done),
		.errors(errors),
		.pending(pending),
		.reads_seen(reads_seen)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Sends one command beat, starting at a falling edge, and waits for its acceptance.
	task automatic send_cmd(logic [2:0] op, int ax, int ay, int bx, int by, int rad,
			logic colour, int bidx);
		cmd.op <= op;
		cmd.ax <= ax[10:0];
		cmd.ay <= ay[10:0];
		cmd.bx <= bx[9:0];
		cmd.by <= by[9:0];
		cmd.radius <= rad[9:0];
		cmd.colour <= colour;
		cmd.byte_index <= bidx[9:0];
		cmd.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cmd.ready);
		beats_sent++;
		@(negedge clk);
	endtask

	// An idle gap with valid low, its length given by n; no gap leaves the next beat back to back.
	task automatic idle_cmd(int n);
		if (n > 0) begin
			cmd.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Random command, mostly small shapes near the screen with some wild coordinates.
	task automatic random_cmd();
		int r, ax, ay, bx, by, rad, bidx;
		logic [2:0] op;
		r = $urandom_range(0, 99);
		if (r < 22)
			op = mfde_pkg::OP_PIXEL;
		else if (r < 40)
			op = mfde_pkg::OP_LINE;
		else if (r < 52)
			op = mfde_pkg::OP_CIRCLE;
		else if (r < 62)
			op = mfde_pkg::OP_FCIRCLE;
		else if (r < 64)
			op = mfde_pkg::OP_FILL;
		else if (r < 67)
			op = mfde_pkg::OP_INVERT;
		else if (r < 98)
			op = mfde_pkg::OP_READ;
		else
			op = OP_UNUSED;
		if ($urandom_range(0, 9) == 0) begin
			ax = $urandom_range(0, 2047) - 1024;
			ay = $urandom_range(0, 2047) - 1024;
			bx = $urandom_range(0, 1023);
			by = $urandom_range(0, 1023);
		end else begin
			ax = $urandom_range(0, 159) - 16;
			ay = $urandom_range(0, 95) - 16;
			bx = $urandom_range(0, 150);
			by = $urandom_range(0, 80);
		end
		rad = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
		bidx = $urandom_range(0, 1023);
		send_cmd(op, ax, ay, bx, by, rad, $urandom_range(0, 1), bidx);
	endtask

	// Result side ready: random stalls, plus a long hold-off when asked.
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_results || $urandom_range(0, 3) == 0)
				rsp.ready <= 1'b0;
			else if ($urandom_range(0, 40) == 0) begin
				rsp.ready <= 1'b0;
				repeat (pick_gap()) @(negedge clk);
			end else
				rsp.ready <= 1'b1;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		cycle_count = 0;
		beats_sent = 0;
		hold_results = 1'b0;
		cmd.valid = 1'b0;
		cmd.op = mfde_pkg::OP_PIXEL;
		cmd.ax = '0;
		cmd.ay = '0;
		cmd.bx = '0;
		cmd.by = '0;
		cmd.radius = '0;
		cmd.colour = 1'b0;
		cmd.byte_index = '0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: extremes of the coordinate and byte index fields, every command and the special cases.
		send_cmd(mfde_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 1'b1, 0);
		send_cmd(mfde_pkg::OP_PIXEL, 127, 63, 0, 0, 0, 1'b1, 0);
		send_cmd(mfde_pkg::OP_PIXEL, -1024, 1023, 0, 0, 0, 1'b1, 0);
		send_cmd(mfde_pkg::OP_READ, 0, 0, 0, 0, 0, 1'b0, 0);
		send_cmd(mfde_pkg::OP_READ, 0, 0, 0, 0, 0, 1'b0, 1023);
		// Negative start clamps to zero; far end clamps to the last column and row.
		send_cmd(mfde_pkg::OP_LINE, -1024, -1024, 1023, 1023, 0, 1'b1, 0);
		send_cmd(mfde_pkg::OP_LINE, 5, 2, 5, 40, 0, 1'b1, 0);
		send_cmd(mfde_pkg::OP_LINE, 100, 30, 3, 30, 0, 1'b1, 0);
		send_cmd(mfde_pkg::OP_LINE, 90, 50, 10, 7, 0, 1'b1, 0);
		send_cmd(mfde_pkg::OP_READ, 0, 0, 0, 0, 0, 1'b0, 5);
		// A circle crossing the edges, and a filled one whose spans must clip.
		send_cmd(mfde_pkg::OP_CIRCLE, 2, 60, 0, 0, 20, 1'b1, 0);
		send_cmd(mfde_pkg::OP_FCIRCLE, 125, 3, 0, 0, 30, 1'b1, 0);
		send_cmd(mfde_pkg::OP_CIRCLE, 1023, -1024, 0, 0, 0, 1'b1, 0);
		send_cmd(mfde_pkg::OP_FCIRCLE, 64, 32, 0, 0, 0, 1'b0, 0);
		send_cmd(mfde_pkg::OP_READ, 0, 0, 0, 0, 0, 1'b0, 130);
		send_cmd(mfde_pkg::OP_INVERT, 0, 0, 0, 0, 0, 1'b0, 0);
		send_cmd(mfde_pkg::OP_PIXEL, 10, 10, 0, 0, 0, 1'b1, 0);
		send_cmd(mfde_pkg::OP_READ, 0, 0, 0, 0, 0, 1'b0, 138);
		send_cmd(mfde_pkg::OP_FILL, 0, 0, 0, 0, 0, 1'b1, 0);
		send_cmd(mfde_pkg::OP_READ, 0, 0, 0, 0, 0, 1'b0, 777);
		send_cmd(mfde_pkg::OP_INVERT, 0, 0, 0, 0, 0, 1'b0, 0);
		send_cmd(OP_UNUSED, 0, 0, 0, 0, 0, 1'b1, 1023);
		send_cmd(mfde_pkg::OP_FILL, 0, 0, 0, 0, 0, 1'b0, 0);
		send_cmd(mfde_pkg::OP_READ, 0, 0, 0, 0, 0, 1'b0, 0);

		// The result side holds off while commands keep coming, so the block backs up.
		hold_results = 1'b1;
		fork
			begin
				repeat (400) @(negedge clk);
				hold_results = 1'b0;
			end
			repeat (6) send_cmd(mfde_pkg::OP_PIXEL, $urandom_range(0, 127),
				$urandom_range(0, 63), 0, 0, 0, 1'b1, 0);
		join

		// The sender pauses until every outstanding result has come back.
		cmd.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);

		// Random part, with idle gaps between some beats.
		for (int n = 0; n < 800; n++) begin
			random_cmd();
			if ($urandom_range(0, 2) == 0)
				idle_cmd(pick_gap());
		end
		cmd.valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);

		$display("Sent %0d command beats covering every draw op, fills, inversion and %0d reads.",
			beats_sent, reads_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
